[src/shooter_inject_and_speed_ready_macros.svh]
// Assertion macros for the shooter injector and speed readiness block.
// Used by the port checker; expects clk and arst_n in the including scope.
`ifndef SHOOTER_INJECT_AND_SPEED_READY_MACROS_SVH
`define SHOOTER_INJECT_AND_SPEED_READY_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SISR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sisr check failed");

// Next-cycle implication, checked out of reset
`define SISR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sisr check failed");

`endif

[src/sisr_pkg.sv]
// Shared types and constants for the shooter injector and speed readiness block.
// No dependencies; used by the interfaces and every module.
package sisr_pkg;

	// Field widths
	localparam int REQ_W    = 2;
	localparam int SPEED_W  = 16;
	localparam int POS_W    = 3;
	localparam int TGT_W    = 15;
	localparam int TOL_W    = 14;
	localparam int TICKS_W  = 8;
	localparam int STABLE_W = 10;
	localparam int RPT_W    = 4;
	localparam int DIST_W   = 2;
	localparam int DRIVE_W  = 2;
	localparam int LIMIT_W  = TGT_W + TOL_W;
	localparam int LHS_W    = 30;

	// APB
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Arithmetic constants
	localparam logic [STABLE_W-1:0] STABLE_LIMIT = 10'd1000;
	localparam logic [LHS_W-1:0]    TOL_SCALE    = 30'd10000;

	// Register reset values
	localparam logic [TGT_W-1:0]    RST_TARGET_SPEED   = 15'd3200;
	localparam logic [TOL_W-1:0]    RST_TOLERANCE      = 14'd25;
	localparam logic [TICKS_W-1:0]  RST_INJECT_TICKS   = 8'd18;
	localparam logic [STABLE_W-1:0] RST_STABLE_REPORTS = 10'd3;
	localparam logic [RPT_W-1:0]    RST_REPORT_TICKS   = 4'd9;
	localparam logic [LIMIT_W-1:0]  RST_TOL_LIMIT      = 29'd80000;

	// Sensed position codes that match a distance target
	localparam logic [POS_W-1:0] POS_RETRACTED = 3'd1;
	localparam logic [POS_W-1:0] POS_CENTER    = 3'd3;
	localparam logic [POS_W-1:0] POS_EXTENDED  = 3'd5;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK   = 2'd0,
		REQ_INJECT = 2'd1,
		REQ_START  = 2'd2,
		REQ_STOP   = 2'd3
	} req_t;

	typedef enum logic [DRIVE_W-1:0] {
		MODE_OFF = 2'd0,
		MODE_REV = 2'd1,
		MODE_FWD = 2'd2
	} mode_t;

	typedef enum logic [DIST_W-1:0] {
		DIST_UNKNOWN = 2'd0,
		DIST_SHORT   = 2'd1,
		DIST_MID     = 2'd2,
		DIST_LONG    = 2'd3
	} dist_t;

	typedef enum logic [2:0] {
		REG_TARGET_SPEED   = 3'd0,
		REG_TOLERANCE      = 3'd1,
		REG_INJECT_TICKS   = 3'd2,
		REG_STABLE_REPORTS = 3'd3,
		REG_REPORT_TICKS   = 3'd4,
		REG_TARGET_DIST    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [TGT_W-1:0]    target_speed;
		logic [TOL_W-1:0]    tolerance;
		logic [TICKS_W-1:0]  inject_ticks;
		logic [STABLE_W-1:0] stable_reports;
		logic [RPT_W-1:0]    report_ticks;
		logic [DIST_W-1:0]   target_distance;
		logic [LIMIT_W-1:0]  tol_limit;
	} cfg_t;

	typedef struct packed {
		logic [REQ_W-1:0]          req_type;
		logic signed [SPEED_W-1:0] measured_speed;
		logic [POS_W-1:0]          sensed_position;
	} item_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] injector_drive;
		logic [DIST_W-1:0]  positioner_command;
		logic               up_to_speed;
		logic               in_position;
		logic               injector_active;
		logic               ready_to_shoot;
		logic               report_strobe;
	} result_t;

endpackage

[src/sisr_if.sv]
// Valid/ready channel interfaces for event beats and result beats.
// Depends on sisr_pkg for field widths.
interface sisr_ev_if;
	logic                                valid;
	logic                                ready;
	logic [sisr_pkg::REQ_W-1:0]          req_type;
	logic signed [sisr_pkg::SPEED_W-1:0] measured_speed;
	logic [sisr_pkg::POS_W-1:0]          sensed_position;

	modport source(output valid, req_type, measured_speed, sensed_position, input ready);
	modport sink(input valid, req_type, measured_speed, sensed_position, output ready);
endinterface

interface sisr_rs_if;
	logic                             valid;
	logic                             ready;
	logic [sisr_pkg::DRIVE_W-1:0]     injector_drive;
	logic [sisr_pkg::DIST_W-1:0]      positioner_command;
	logic                             up_to_speed;
	logic                             in_position;
	logic                             injector_active;
	logic                             ready_to_shoot;
	logic                             report_strobe;

	modport source(output valid, injector_drive, positioner_command, up_to_speed,
		in_position, injector_active, ready_to_shoot, report_strobe, input ready);
	modport sink(input valid, injector_drive, positioner_command, up_to_speed,
		in_position, injector_active, ready_to_shoot, report_strobe, output ready);
endinterface

[src/sisr_cfg_regs.sv]
// APB configuration registers and the registered tolerance limit.
// Depends on sisr_pkg.
module sisr_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sisr_pkg::ADDR_W-1:0]   paddr,
	input  logic [sisr_pkg::DATA_W-1:0]   pwdata,
	output logic [sisr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output sisr_pkg::cfg_t                cfg
);
	logic [sisr_pkg::TGT_W-1:0]    target_speed_q;
	logic [sisr_pkg::TOL_W-1:0]    tolerance_q;
	logic [sisr_pkg::TICKS_W-1:0]  inject_ticks_q;
	logic [sisr_pkg::STABLE_W-1:0] stable_reports_q;
	logic [sisr_pkg::RPT_W-1:0]    report_ticks_q;
	logic [sisr_pkg::DIST_W-1:0]   target_distance_q;
	logic [sisr_pkg::LIMIT_W-1:0]  tol_limit_q;
	sisr_pkg::reg_idx_t            idx;
	logic                          wr_en;

	assign pready = 1'b1;
	assign idx    = sisr_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_speed_q    <= sisr_pkg::RST_TARGET_SPEED;
			tolerance_q       <= sisr_pkg::RST_TOLERANCE;
			inject_ticks_q    <= sisr_pkg::RST_INJECT_TICKS;
			stable_reports_q  <= sisr_pkg::RST_STABLE_REPORTS;
			report_ticks_q    <= sisr_pkg::RST_REPORT_TICKS;
			target_distance_q <= sisr_pkg::DIST_UNKNOWN;
		end else if (wr_en) begin
			unique case (idx)
				sisr_pkg::REG_TARGET_SPEED:   target_speed_q    <= pwdata[sisr_pkg::TGT_W-1:0];
				sisr_pkg::REG_TOLERANCE:      tolerance_q       <= pwdata[sisr_pkg::TOL_W-1:0];
				sisr_pkg::REG_INJECT_TICKS:   inject_ticks_q    <= pwdata[sisr_pkg::TICKS_W-1:0];
				sisr_pkg::REG_STABLE_REPORTS: stable_reports_q  <= pwdata[sisr_pkg::STABLE_W-1:0];
				sisr_pkg::REG_REPORT_TICKS:   report_ticks_q    <= pwdata[sisr_pkg::RPT_W-1:0];
				sisr_pkg::REG_TARGET_DIST:    target_distance_q <= pwdata[sisr_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Target times tolerance, refreshed every cycle; updates the cycle after a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_limit_q <= sisr_pkg::RST_TOL_LIMIT;
		end else begin
			tol_limit_q <= {{sisr_pkg::TOL_W{1'b0}}, target_speed_q} *
				{{sisr_pkg::TGT_W{1'b0}}, tolerance_q};
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			sisr_pkg::REG_TARGET_SPEED:   prdata = sisr_pkg::DATA_W'(target_speed_q);
			sisr_pkg::REG_TOLERANCE:      prdata = sisr_pkg::DATA_W'(tolerance_q);
			sisr_pkg::REG_INJECT_TICKS:   prdata = sisr_pkg::DATA_W'(inject_ticks_q);
			sisr_pkg::REG_STABLE_REPORTS: prdata = sisr_pkg::DATA_W'(stable_reports_q);
			sisr_pkg::REG_REPORT_TICKS:   prdata = sisr_pkg::DATA_W'(report_ticks_q);
			sisr_pkg::REG_TARGET_DIST:    prdata = sisr_pkg::DATA_W'(target_distance_q);
			default:                      prdata = '0;
		endcase
	end

	assign cfg.target_speed    = target_speed_q;
	assign cfg.tolerance       = tolerance_q;
	assign cfg.inject_ticks    = inject_ticks_q;
	assign cfg.stable_reports  = stable_reports_q;
	assign cfg.report_ticks    = report_ticks_q;
	assign cfg.target_distance = target_distance_q;
	assign cfg.tol_limit       = tol_limit_q;

endmodule

[src/sisr_core.sv]
// Injector sequencer, report counter and speed check state with next-result logic.
// Depends on sisr_pkg.
module sisr_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  sisr_pkg::item_t      item,
	input  sisr_pkg::cfg_t       cfg,
	output sisr_pkg::result_t    res
);
	sisr_pkg::mode_t               mode_q, mode_d;
	logic [sisr_pkg::TICKS_W-1:0]  cnt_q, cnt_d, cnt_inc, cnt_dec;
	logic [sisr_pkg::RPT_W-1:0]    rc_q, rc_d, rc_inc;
	logic [sisr_pkg::STABLE_W-1:0] sc_q, sc_d, sc_inc;
	logic                          ok_q, ok_d;
	logic                          run_q, run_d;
	logic                          strobe;
	logic                          report_hit;
	logic signed [sisr_pkg::SPEED_W:0] err;
	logic [sisr_pkg::SPEED_W:0]    mag_full;
	logic [sisr_pkg::LHS_W-1:0]    lhs;
	logic                          in_tol;
	logic                          in_pos;

	// Counter steps; the injector and stable counters saturate
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 8'd1;
	assign cnt_dec = (cnt_q != '0) ? cnt_q - 8'd1 : cnt_q;
	assign rc_inc  = rc_q + 4'd1;
	assign sc_inc  = (sc_q < sisr_pkg::STABLE_LIMIT) ? sc_q + 10'd1 : sc_q;
	assign report_hit = rc_inc >= cfg.report_ticks;

	// Speed error magnitude scaled against target times tolerance
	assign err      = {item.measured_speed[sisr_pkg::SPEED_W-1], item.measured_speed}
		- $signed({2'b00, cfg.target_speed});
	assign mag_full = err[sisr_pkg::SPEED_W] ? 17'(-err) : 17'(err);
	assign lhs      = {14'd0, mag_full[sisr_pkg::SPEED_W-1:0]} * sisr_pkg::TOL_SCALE;
	assign in_tol   = lhs < {1'b0, cfg.tol_limit};

	// Next state for the event in hand
	always_comb begin
		mode_d = mode_q;
		cnt_d  = cnt_q;
		rc_d   = rc_q;
		sc_d   = sc_q;
		ok_d   = ok_q;
		run_d  = run_q;
		strobe = 1'b0;
		unique case (sisr_pkg::req_t'(item.req_type))
			sisr_pkg::REQ_TICK: begin
				if (run_q) begin
					case (mode_q)
						sisr_pkg::MODE_REV: begin
							cnt_d = cnt_inc;
							if (cnt_inc >= cfg.inject_ticks)
								mode_d = sisr_pkg::MODE_FWD;
						end
						sisr_pkg::MODE_FWD: begin
							cnt_d = cnt_dec;
							if (cnt_dec == '0)
								mode_d = sisr_pkg::MODE_OFF;
						end
						default: ;
					endcase
					rc_d = rc_inc;
					if (report_hit) begin
						rc_d   = '0;
						strobe = 1'b1;
						if (in_tol) begin
							sc_d = sc_inc;
							ok_d = sc_inc >= cfg.stable_reports;
						end else begin
							sc_d = '0;
							ok_d = 1'b0;
						end
					end
				end
			end
			sisr_pkg::REQ_INJECT: begin
				mode_d = sisr_pkg::MODE_REV;
				cnt_d  = cnt_inc;
			end
			sisr_pkg::REQ_START: begin
				rc_d  = '0;
				run_d = 1'b1;
			end
			sisr_pkg::REQ_STOP: begin
				run_d  = 1'b0;
				mode_d = sisr_pkg::MODE_OFF;
				sc_d   = '0;
				ok_d   = 1'b0;
			end
			default: ;
		endcase
	end

	// Sensed position against the distance target
	always_comb begin
		case (sisr_pkg::dist_t'(cfg.target_distance))
			sisr_pkg::DIST_SHORT: in_pos = item.sensed_position == sisr_pkg::POS_RETRACTED;
			sisr_pkg::DIST_MID:   in_pos = item.sensed_position == sisr_pkg::POS_CENTER;
			sisr_pkg::DIST_LONG:  in_pos = item.sensed_position == sisr_pkg::POS_EXTENDED;
			default:              in_pos = 1'b1;
		endcase
	end

	// Hold state; advance only when the event moves on to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sisr_pkg::MODE_OFF;
			cnt_q  <= '0;
			rc_q   <= '0;
			sc_q   <= '0;
			ok_q   <= 1'b0;
			run_q  <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			rc_q   <= rc_d;
			sc_q   <= sc_d;
			ok_q   <= ok_d;
			run_q  <= run_d;
		end
	end

	// Result reflects the updated state
	assign res.injector_drive     = mode_d;
	assign res.positioner_command = cfg.target_distance;
	assign res.up_to_speed        = ok_d;
	assign res.in_position        = in_pos;
	assign res.injector_active    = cnt_d != '0;
	assign res.ready_to_shoot     = in_pos && ok_d && (cnt_d == '0);
	assign res.report_strobe      = strobe;

endmodule

[src/shooter_inject_and_speed_ready.sv]
// Shooter injector sequencer and wheel-speed readiness monitor, top level.
// Depends on sisr_pkg, sisr_if, sisr_cfg_regs and sisr_core.
//
// Usage:
//   events  - valid/ready channel of event beats: poll tick, inject, start, stop,
//             with the measured wheel speed and the sensed positioner code.
//   results - valid/ready channel with one result beat per event: injector drive,
//             positioner command, up to speed, in position, injector active,
//             ready to shoot and the report strobe.
//   APB     - six configuration registers at byte offsets 0x00..0x14; write them
//             only while no event is in flight.
// Each event is held in the event register, and its result beat is loaded from
// the core into the result register once the result register is free or taken.
// Throughput: one event per cycle while results are taken; the event register and
// the result register form a two-stage pipeline, and all state updates on the move between them.
// Reset clears the injector, report and stable counters and the run flag, and
// loads the register defaults. When the receiver stalls, the result register
// holds its beat and an empty event register still takes one more event, after which
// events.ready drops until the result is taken.
module shooter_inject_and_speed_ready (
	input  logic                          clk,
	input  logic                          arst_n,
	sisr_ev_if.sink                       events,
	sisr_rs_if.source                     results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sisr_pkg::ADDR_W-1:0]   paddr,
	input  logic [sisr_pkg::DATA_W-1:0]   pwdata,
	output logic [sisr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	sisr_pkg::cfg_t    cfg;
	sisr_pkg::item_t   item_s1;
	sisr_pkg::result_t res_d;
	sisr_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;
	logic              fire;

	sisr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Pipeline handshake
	assign advance       = !valid_s2 || results.ready;
	assign fire          = valid_s1 && advance;
	assign events.ready  = !valid_s1 || advance;

	// Event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.ready && events.valid) begin
			item_s1.req_type        <= events.req_type;
			item_s1.measured_speed  <= events.measured_speed;
			item_s1.sensed_position <= events.sensed_position;
		end
	end

	sisr_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.cfg   (cfg),
		.res   (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	assign results.valid              = valid_s2;
	assign results.injector_drive     = res_s2.injector_drive;
	assign results.positioner_command = res_s2.positioner_command;
	assign results.up_to_speed        = res_s2.up_to_speed;
	assign results.in_position        = res_s2.in_position;
	assign results.injector_active    = res_s2.injector_active;
	assign results.ready_to_shoot     = res_s2.ready_to_shoot;
	assign results.report_strobe      = res_s2.report_strobe;

endmodule

[src/sisr_checker.sv]
// Port-level checks for the shooter injector and speed readiness block, bound to the top.
// Depends on sisr_pkg and shooter_inject_and_speed_ready_macros.svh.
`include "shooter_inject_and_speed_ready_macros.svh"

module sisr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        ev_valid,
	input logic                        ev_ready,
	input logic                        rs_valid,
	input logic                        rs_ready,
	input logic [sisr_pkg::DRIVE_W-1:0] injector_drive,
	input logic                        up_to_speed,
	input logic                        in_position,
	input logic                        injector_active,
	input logic                        ready_to_shoot,
	input logic                        report_strobe
);
	// Ready to shoot only from its three conditions
	`SISR_ASSERT_IMP(a_ready_combo, rs_valid && ready_to_shoot,
		up_to_speed && in_position && !injector_active)

	// A new result beat follows an accepted event
	`SISR_ASSERT_IMP(a_result_source, $rose(rs_valid), $past(ev_valid && ev_ready, 2))

	// Stalled result beat holds
	`SISR_ASSERT_NXT(a_result_hold, rs_valid && !rs_ready,
		rs_valid && $stable(injector_drive) && $stable(ready_to_shoot) && $stable(report_strobe))

endmodule

bind shooter_inject_and_speed_ready sisr_checker u_sisr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.ev_valid       (events.valid),
	.ev_ready       (events.ready),
	.rs_valid       (results.valid),
	.rs_ready       (results.ready),
	.injector_drive (results.injector_drive),
	.up_to_speed    (results.up_to_speed),
	.in_position    (results.in_position),
	.injector_active(results.injector_active),
	.ready_to_shoot (results.ready_to_shoot),
	.report_strobe  (results.report_strobe)
);

[dv/shooter_inject_and_speed_ready_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the shooter injector sequencer and speed readiness block.
// Drives event beats and APB register writes, predicts each result beat in-line and
// compares it; depends on sisr_pkg, sisr_if and the block's RTL.
module shooter_inject_and_speed_ready_test;

	typedef struct {
		bit                                  is_write;
		sisr_pkg::reg_idx_t                  reg_sel;
		logic [sisr_pkg::DATA_W-1:0]         wval;
		sisr_pkg::req_t                      req;
		logic signed [sisr_pkg::SPEED_W-1:0] speed;
		logic [sisr_pkg::POS_W-1:0]          pos;
		bit                                  fixed;
		sisr_pkg::result_t                   res;
	} plan_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [sisr_pkg::ADDR_W-1:0] paddr;
	logic [sisr_pkg::DATA_W-1:0] pwdata;
	logic [sisr_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	sisr_ev_if ev_ch();
	sisr_rs_if rs_ch();

	shooter_inject_and_speed_ready u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (ev_ch),
		.results (rs_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the registers
	logic [sisr_pkg::TGT_W-1:0]    cfg_target = sisr_pkg::RST_TARGET_SPEED;
	logic [sisr_pkg::TOL_W-1:0]    cfg_tol    = sisr_pkg::RST_TOLERANCE;
	logic [sisr_pkg::TICKS_W-1:0]  cfg_inject = sisr_pkg::RST_INJECT_TICKS;
	logic [sisr_pkg::STABLE_W-1:0] cfg_stable = sisr_pkg::RST_STABLE_REPORTS;
	logic [sisr_pkg::RPT_W-1:0]    cfg_report = sisr_pkg::RST_REPORT_TICKS;
	sisr_pkg::dist_t               cfg_dist   = sisr_pkg::DIST_UNKNOWN;

	// Shadow copy of the sequencer and speed monitor state
	sisr_pkg::mode_t               inj_mode   = sisr_pkg::MODE_OFF;
	logic [sisr_pkg::TICKS_W-1:0]  inj_count  = '0;
	logic [sisr_pkg::RPT_W-1:0]    rpt_count  = '0;
	logic [sisr_pkg::STABLE_W-1:0] stable_cnt = '0;
	bit                            speed_ok   = 1'b0;
	bit                            running    = 1'b0;

	sisr_pkg::result_t beat_q[$];
	plan_row_t         plan[$];
	int unsigned       err_count = 0;
	int                src_idle_pct = 0;
	int                rcv_stall_pct = 0;
	bit                cur_fixed = 1'b0;
	sisr_pkg::result_t cur_res = '0;

	int phase_items [5] = '{80, 320, 130, 130, 80};
	int phase_src   [5] = '{0, 84, 0, 21, 0};
	int phase_rcv   [5] = '{0, 0, 84, 21, 0};

	always #5 clk = ~clk;

	// Exact band check: |meas - target| * 10000 < target * tolerance
	function automatic bit speed_in_band(logic signed [sisr_pkg::SPEED_W-1:0] meas);
		longint diff;
		longint mag;
		diff = longint'(meas) - longint'(cfg_target);
		mag = (diff < 0) ? -diff : diff;
		return (mag * 10000) < (longint'(cfg_target) * longint'(cfg_tol));
	endfunction

	// Advance the shadow state by one event and build its result beat
	function automatic sisr_pkg::result_t predict_beat(sisr_pkg::req_t req,
			logic signed [sisr_pkg::SPEED_W-1:0] speed, logic [sisr_pkg::POS_W-1:0] pos);
		sisr_pkg::result_t r;
		bit                strobe;
		bit                inpos;
		strobe = 1'b0;
		case (req)
			sisr_pkg::REQ_TICK: begin
				if (running) begin
					if (inj_mode == sisr_pkg::MODE_REV) begin
						if (inj_count != 8'hFF) inj_count++;
						if (inj_count >= cfg_inject) inj_mode = sisr_pkg::MODE_FWD;
					end else if (inj_mode == sisr_pkg::MODE_FWD) begin
						if (inj_count != 0) inj_count--;
						if (inj_count == 0) inj_mode = sisr_pkg::MODE_OFF;
					end
					rpt_count = rpt_count + 1'b1;
					if (rpt_count >= cfg_report) begin
						rpt_count = '0;
						strobe = 1'b1;
						if (speed_in_band(speed)) begin
							if (stable_cnt < sisr_pkg::STABLE_LIMIT) stable_cnt++;
							speed_ok = (stable_cnt >= cfg_stable);
						end else begin
							stable_cnt = '0;
							speed_ok = 1'b0;
						end
					end
				end
			end
			sisr_pkg::REQ_INJECT: begin
				inj_mode = sisr_pkg::MODE_REV;
				if (inj_count != 8'hFF) inj_count++;
			end
			sisr_pkg::REQ_START: begin
				rpt_count = '0;
				running = 1'b1;
			end
			default: begin
				running = 1'b0;
				inj_mode = sisr_pkg::MODE_OFF;
				stable_cnt = '0;
				speed_ok = 1'b0;
			end
		endcase
		case (cfg_dist)
			sisr_pkg::DIST_SHORT: inpos = (pos == sisr_pkg::POS_RETRACTED);
			sisr_pkg::DIST_MID:   inpos = (pos == sisr_pkg::POS_CENTER);
			sisr_pkg::DIST_LONG:  inpos = (pos == sisr_pkg::POS_EXTENDED);
			default:              inpos = 1'b1;
		endcase
		r.injector_drive     = inj_mode;
		r.positioner_command = cfg_dist;
		r.up_to_speed        = speed_ok;
		r.in_position        = inpos;
		r.injector_active    = (inj_count != 0);
		r.ready_to_shoot     = inpos && speed_ok && (inj_count == 0);
		r.report_strobe      = strobe;
		return r;
	endfunction

	// Result beat with the target unknown, not up to speed and no report
	function automatic sisr_pkg::result_t quiet_res(sisr_pkg::mode_t drive, bit act);
		sisr_pkg::result_t r;
		r = '0;
		r.injector_drive  = drive;
		r.in_position     = 1'b1;
		r.injector_active = act;
		return r;
	endfunction

	function automatic void add_ev(sisr_pkg::req_t req, int sp, int pos, bit fixed,
			sisr_pkg::result_t res);
		plan_row_t row;
		row.is_write = 1'b0;
		row.reg_sel  = sisr_pkg::REG_TARGET_SPEED;
		row.wval     = '0;
		row.req      = req;
		row.speed    = sisr_pkg::SPEED_W'(sp);
		row.pos      = sisr_pkg::POS_W'(pos);
		row.fixed    = fixed;
		row.res      = res;
		plan.push_back(row);
	endfunction

	function automatic void add_wr(sisr_pkg::reg_idx_t sel, int unsigned val);
		plan_row_t row;
		row.is_write = 1'b1;
		row.reg_sel  = sel;
		row.wval     = val;
		row.req      = sisr_pkg::REQ_TICK;
		row.speed    = '0;
		row.pos      = '0;
		row.fixed    = 1'b0;
		row.res      = '0;
		plan.push_back(row);
	endfunction

	// Put garbage above the register's width; the block keeps only the low bits
	function automatic logic [sisr_pkg::DATA_W-1:0] with_junk(int unsigned val, int w);
		logic [sisr_pkg::DATA_W-1:0] hi;
		hi = $urandom();
		return (hi << w) | sisr_pkg::DATA_W'(val);
	endfunction

	// One APB write: setup cycle, then access cycle until pready
	task automatic apb_write(sisr_pkg::reg_idx_t sel, logic [sisr_pkg::DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (sel)
			sisr_pkg::REG_TARGET_SPEED:   cfg_target = val[sisr_pkg::TGT_W-1:0];
			sisr_pkg::REG_TOLERANCE:      cfg_tol    = val[sisr_pkg::TOL_W-1:0];
			sisr_pkg::REG_INJECT_TICKS:   cfg_inject = val[sisr_pkg::TICKS_W-1:0];
			sisr_pkg::REG_STABLE_REPORTS: cfg_stable = val[sisr_pkg::STABLE_W-1:0];
			sisr_pkg::REG_REPORT_TICKS:   cfg_report = val[sisr_pkg::RPT_W-1:0];
			default: cfg_dist = sisr_pkg::dist_t'(val[sisr_pkg::DIST_W-1:0]);
		endcase
	endtask

	// Hold off events until every result beat is back, then let the pipe settle
	task automatic drain_results();
		ev_ch.valid <= 1'b0;
		do @(posedge clk); while (beat_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Offer one event beat, with random idle cycles ahead of it
	task automatic send_event(sisr_pkg::req_t req, logic signed [sisr_pkg::SPEED_W-1:0] speed,
			logic [sisr_pkg::POS_W-1:0] pos, bit fixed, sisr_pkg::result_t res);
		while ($urandom_range(99) < src_idle_pct) begin
			ev_ch.valid <= 1'b0;
			@(posedge clk);
		end
		ev_ch.valid           <= 1'b1;
		ev_ch.req_type        <= req;
		ev_ch.measured_speed  <= speed;
		ev_ch.sensed_position <= pos;
		cur_fixed             <= fixed;
		cur_res               <= res;
		do @(posedge clk); while (!ev_ch.ready);
	endtask

	// Mostly running poll ticks with speeds near the target band
	task automatic send_random(bit calm, bit force_start);
		int                         pick;
		int                         band;
		int                         off;
		int                         sp;
		sisr_pkg::req_t             req;
		logic [sisr_pkg::POS_W-1:0] pos;
		pick = $urandom_range(99);
		if (force_start) req = sisr_pkg::REQ_START;
		else if (pick < (calm ? 94 : 85)) req = sisr_pkg::REQ_TICK;
		else if (pick < (calm ? 98 : 92)) req = sisr_pkg::REQ_INJECT;
		else if (pick < (calm ? 99 : 97)) req = sisr_pkg::REQ_START;
		else req = sisr_pkg::REQ_STOP;
		band = (int'(cfg_target) * int'(cfg_tol)) / 10000;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: begin
				off = $urandom_range(band + 1);
				if ($urandom_range(1)) off = -off;
				sp = int'(cfg_target) + off;
			end
			5: sp = int'(cfg_target);
			default: sp = $urandom_range(65535) - 32768;
		endcase
		if (sp > 32767) sp = 32767;
		if (sp < -32768) sp = -32768;
		pos = sisr_pkg::POS_W'($urandom_range(7));
		if ($urandom_range(1)) begin
			case (cfg_dist)
				sisr_pkg::DIST_SHORT: pos = sisr_pkg::POS_RETRACTED;
				sisr_pkg::DIST_MID:   pos = sisr_pkg::POS_CENTER;
				sisr_pkg::DIST_LONG:  pos = sisr_pkg::POS_EXTENDED;
				default:              pos = sisr_pkg::POS_W'($urandom_range(7));
			endcase
		end
		send_event(req, sisr_pkg::SPEED_W'(sp), pos, 1'b0, '0);
	endtask

	// Load all six registers for one phase and pick its idling
	task automatic set_phase(int p);
		int unsigned tgt, tol, itk, stb, rpt, dst;
		case (p)
			0: begin
				tgt = 0; tol = 0; itk = 0; stb = 0; rpt = 0; dst = sisr_pkg::DIST_UNKNOWN;
			end
			1: begin
				tgt = 32767; tol = 16383; itk = 255; stb = 1023; rpt = 15;
				dst = sisr_pkg::DIST_LONG;
			end
			4: begin
				tgt = 3200; tol = 10000; itk = 1; stb = 1000; rpt = 1;
				dst = sisr_pkg::DIST_MID;
			end
			default: begin
				tgt = $urandom_range(32767);
				tol = $urandom_range(10000, 10);
				itk = $urandom_range(12, 1);
				stb = $urandom_range(4);
				rpt = $urandom_range(4, 1);
				dst = $urandom_range(3);
			end
		endcase
		apb_write(sisr_pkg::REG_TARGET_SPEED, with_junk(tgt, sisr_pkg::TGT_W));
		apb_write(sisr_pkg::REG_TOLERANCE, with_junk(tol, sisr_pkg::TOL_W));
		apb_write(sisr_pkg::REG_INJECT_TICKS, with_junk(itk, sisr_pkg::TICKS_W));
		apb_write(sisr_pkg::REG_STABLE_REPORTS, with_junk(stb, sisr_pkg::STABLE_W));
		apb_write(sisr_pkg::REG_REPORT_TICKS, with_junk(rpt, sisr_pkg::RPT_W));
		apb_write(sisr_pkg::REG_TARGET_DIST, with_junk(dst, sisr_pkg::DIST_W));
		src_idle_pct  = phase_src[p];
		rcv_stall_pct = phase_rcv[p];
	endtask

	// Directed events on the reset registers, then on zeroed counts and each distance target
	function automatic void build_plan();
		add_ev(sisr_pkg::REQ_TICK, 0, 0, 1'b1, quiet_res(sisr_pkg::MODE_OFF, 1'b0));
		add_ev(sisr_pkg::REQ_TICK, 32767, 7, 1'b1, quiet_res(sisr_pkg::MODE_OFF, 1'b0));
		add_ev(sisr_pkg::REQ_TICK, -32768, 6, 1'b1, quiet_res(sisr_pkg::MODE_OFF, 1'b0));
		add_ev(sisr_pkg::REQ_INJECT, 0, 2, 1'b1, quiet_res(sisr_pkg::MODE_REV, 1'b1));
		add_ev(sisr_pkg::REQ_STOP, 0, 4, 1'b1, quiet_res(sisr_pkg::MODE_OFF, 1'b1));
		add_ev(sisr_pkg::REQ_START, 0, 0, 1'b1, quiet_res(sisr_pkg::MODE_OFF, 1'b1));
		add_ev(sisr_pkg::REQ_INJECT, 0, 0, 1'b1, quiet_res(sisr_pkg::MODE_REV, 1'b1));
		add_ev(sisr_pkg::REQ_TICK, 3200, 3, 1'b0, '0);
		add_ev(sisr_pkg::REQ_START, 0, 0, 1'b0, '0);
		// every tick a report, no stable reports needed, immediate forward
		add_wr(sisr_pkg::REG_REPORT_TICKS, 0);
		add_wr(sisr_pkg::REG_STABLE_REPORTS, 0);
		add_wr(sisr_pkg::REG_INJECT_TICKS, 0);
		add_ev(sisr_pkg::REQ_TICK, 3200, 1, 1'b0, '0);
		add_ev(sisr_pkg::REQ_TICK, 3207, 0, 1'b0, '0);
		add_ev(sisr_pkg::REQ_TICK, 3208, 0, 1'b0, '0);
		add_ev(sisr_pkg::REQ_INJECT, 0, 0, 1'b0, '0);
		add_ev(sisr_pkg::REQ_TICK, 3199, 0, 1'b0, '0);
		add_ev(sisr_pkg::REQ_TICK, -32768, 0, 1'b0, '0);
		// walk the distance targets against matching and stray positions
		add_wr(sisr_pkg::REG_TARGET_DIST, sisr_pkg::DIST_SHORT);
		add_ev(sisr_pkg::REQ_TICK, 3200, 1, 1'b0, '0);
		add_ev(sisr_pkg::REQ_TICK, 3200, 3, 1'b0, '0);
		add_wr(sisr_pkg::REG_TARGET_DIST, sisr_pkg::DIST_MID);
		add_ev(sisr_pkg::REQ_TICK, 3200, 3, 1'b0, '0);
		add_wr(sisr_pkg::REG_TARGET_DIST, sisr_pkg::DIST_LONG);
		add_ev(sisr_pkg::REQ_TICK, 3200, 5, 1'b0, '0);
		add_ev(sisr_pkg::REQ_TICK, 3200, 7, 1'b0, '0);
		add_ev(sisr_pkg::REQ_STOP, 0, 5, 1'b0, '0);
		add_ev(sisr_pkg::REQ_TICK, 3200, 5, 1'b0, '0);
	endfunction

	// Receiver: stall ready at random
	initial begin
		rs_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rs_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// Predict each accepted event beat
	always @(posedge clk) begin : accept_mon
		sisr_pkg::result_t next_beat;
		if (arst_n && ev_ch.valid && ev_ch.ready) begin
			next_beat = predict_beat(sisr_pkg::req_t'(ev_ch.req_type), ev_ch.measured_speed,
				ev_ch.sensed_position);
			if (cur_fixed) next_beat = cur_res;
			beat_q.push_back(next_beat);
		end
	end

	// Compare each accepted result beat with the oldest prediction
	always @(posedge clk) begin : beat_check
		sisr_pkg::result_t want;
		if (arst_n && rs_ch.valid && rs_ch.ready) begin
			if (beat_q.size() == 0) begin
				err_count++;
				if (err_count <= 10) $display("result beat with nothing predicted");
			end else begin
				want = beat_q.pop_front();
				if (rs_ch.injector_drive !== want.injector_drive ||
						rs_ch.positioner_command !== want.positioner_command ||
						rs_ch.up_to_speed !== want.up_to_speed ||
						rs_ch.in_position !== want.in_position ||
						rs_ch.injector_active !== want.injector_active ||
						rs_ch.ready_to_shoot !== want.ready_to_shoot ||
						rs_ch.report_strobe !== want.report_strobe) begin
					err_count++;
					if (err_count <= 10)
						$display({"beat diff: exp drv=%0d cmd=%0d up=%b pos=%b act=%b rdy=%b",
							" rpt=%b / got drv=%0d cmd=%0d up=%b pos=%b act=%b rdy=%b rpt=%b"},
							want.injector_drive, want.positioner_command, want.up_to_speed,
							want.in_position, want.injector_active, want.ready_to_shoot,
							want.report_strobe, rs_ch.injector_drive, rs_ch.positioner_command,
							rs_ch.up_to_speed, rs_ch.in_position, rs_ch.injector_active,
							rs_ch.ready_to_shoot, rs_ch.report_strobe);
				end
			end
		end
	end

	// Stimulus: directed plan, then the random phases
	initial begin : stim
		ev_ch.valid           <= 1'b0;
		ev_ch.req_type        <= sisr_pkg::REQ_TICK;
		ev_ch.measured_speed  <= '0;
		ev_ch.sensed_position <= '0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		build_plan();
		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				drain_results();
				apb_write(plan[i].reg_sel, plan[i].wval);
			end else begin
				send_event(plan[i].req, plan[i].speed, plan[i].pos, plan[i].fixed,
					plan[i].res);
			end
		end
		for (int p = 0; p < 5; p++) begin
			drain_results();
			set_phase(p);
			for (int i = 0; i < phase_items[p]; i++) begin
				// pause the sender mid-phase until every beat is back
				if (i == phase_items[p] / 2) drain_results();
				send_random(p == 1, i == 0);
			end
		end
		drain_results();
		if (err_count == 0) begin
			$display("shooter_inject_and_speed_ready: match");
		end else begin
			$display("shooter_inject_and_speed_ready: mismatch");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("shooter_inject_and_speed_ready: mismatch");
		$finish;
	end

endmodule
